// File: rtl/wxh_pkg.sv
// Shared types, constants and helpers for the word xor fmix64 hash block.
`default_nettype none
package wxh_pkg;

   localparam int WordWidth  = 64;
   localparam int HalfWidth  = 32;
   localparam int CountWidth = 4;
   localparam int NumBytes   = 8;
   localparam int MixShift   = 33;

   localparam logic [WordWidth-1:0] SEED_RESET = 64'h5555_AAAA_5555_AAAA;
   localparam logic [WordWidth-1:0] MIX_MUL_A  = 64'hff51_afd7_ed55_8ccd;
   localparam logic [WordWidth-1:0] MIX_MUL_B  = 64'hc4ce_b9fe_1a85_ec53;

   // Mixer sequencer states: one pass of MUL0..MUL3 per 64-bit multiply.
   typedef enum logic [2:0] {
      MX_IDLE,
      MX_MUL0,
      MX_MUL1,
      MX_MUL2,
      MX_MUL3,
      MX_DONE
   } mix_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } mix_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mix_status_type;

   // Keep the low byte_count bytes; counts of eight and above keep the whole word.
   function automatic logic [WordWidth-1:0] mask_bytes(
      input logic [WordWidth-1:0]  w,
      input logic [CountWidth-1:0] count
   );
      logic [WordWidth-1:0] m;
      m = '0;
      for (int i = 0; i < NumBytes; i++) begin
         if (count > CountWidth'(i)) begin
            m[i*8 +: 8] = w[i*8 +: 8];
         end
      end
      return m;
   endfunction

   function automatic logic [WordWidth-1:0] xorshift(input logic [WordWidth-1:0] v);
      return v ^ (v >> MixShift);
   endfunction

endpackage
`default_nettype wire

// File: rtl/wxh_mul_unit.sv
// Shared 32x32 multiplier with a registered 64-bit product.
`default_nettype none
module wxh_mul_unit (
   input  wire logic                              clock,
   input  wire logic [wxh_pkg::HalfWidth-1:0]     mul_a,
   input  wire logic [wxh_pkg::HalfWidth-1:0]     mul_b,
   output logic      [wxh_pkg::WordWidth-1:0]     prod_ff
);

   logic [wxh_pkg::WordWidth-1:0] prod_in;

   assign prod_in = wxh_pkg::WordWidth'(mul_a) * wxh_pkg::WordWidth'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
`default_nettype wire

// File: rtl/wxh_mixer.sv
// Iterative fmix64 engine: xor-shift and two 64-bit multiplies built from
// three 32x32 partial products each on one shared multiplier.
`default_nettype none
module wxh_mixer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire wxh_pkg::mix_ctrl_type          ctrl,
   input  wire logic [wxh_pkg::WordWidth-1:0]  din,
   output wxh_pkg::mix_status_type             status,
   output logic      [wxh_pkg::WordWidth-1:0]  dout
);

   wxh_pkg::mix_state_type state_ff, state_in;
   logic                          pass_ff, pass_in;
   logic [wxh_pkg::WordWidth-1:0] v_ff, v_in;
   logic [wxh_pkg::WordWidth-1:0] sum_ff, sum_in;
   logic [wxh_pkg::WordWidth-1:0] k;
   logic [wxh_pkg::WordWidth-1:0] prod_hi_sh;
   logic [wxh_pkg::WordWidth-1:0] sum_final;
   logic [wxh_pkg::HalfWidth-1:0] mul_a, mul_b;
   logic [wxh_pkg::WordWidth-1:0] prod_ff;

   wxh_mul_unit u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign k          = pass_ff ? wxh_pkg::MIX_MUL_B : wxh_pkg::MIX_MUL_A;
   // cross products only reach the upper half of the truncated result
   assign prod_hi_sh = {prod_ff[wxh_pkg::HalfWidth-1:0], {wxh_pkg::HalfWidth{1'b0}}};
   assign sum_final  = sum_ff + prod_hi_sh;
   assign dout       = v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wxh_pkg::MX_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      sum_ff <= sum_in;
   end

   always_comb begin
      state_in    = state_ff;
      pass_in     = pass_ff;
      v_in        = v_ff;
      sum_in      = sum_ff;
      mul_a       = v_ff[wxh_pkg::HalfWidth-1:0];
      mul_b       = k[wxh_pkg::HalfWidth-1:0];
      status.busy = (state_ff != wxh_pkg::MX_IDLE);
      status.done = 1'b0;
      case (state_ff)
         wxh_pkg::MX_IDLE: begin
            if (ctrl.start) begin
               v_in     = wxh_pkg::xorshift(din);
               pass_in  = 1'b0;
               state_in = wxh_pkg::MX_MUL0;
            end
         end
         wxh_pkg::MX_MUL0: begin
            state_in = wxh_pkg::MX_MUL1;
         end
         wxh_pkg::MX_MUL1: begin
            mul_b    = k[wxh_pkg::WordWidth-1:wxh_pkg::HalfWidth];
            sum_in   = prod_ff;
            state_in = wxh_pkg::MX_MUL2;
         end
         wxh_pkg::MX_MUL2: begin
            mul_a    = v_ff[wxh_pkg::WordWidth-1:wxh_pkg::HalfWidth];
            sum_in   = sum_final;
            state_in = wxh_pkg::MX_MUL3;
         end
         wxh_pkg::MX_MUL3: begin
            v_in = wxh_pkg::xorshift(sum_final);
            if (pass_ff) begin
               state_in = wxh_pkg::MX_DONE;
            end else begin
               pass_in  = 1'b1;
               state_in = wxh_pkg::MX_MUL0;
            end
         end
         wxh_pkg::MX_DONE: begin
            status.done = 1'b1;
            if (ctrl.ack) begin
               state_in = wxh_pkg::MX_IDLE;
            end
         end
         default: begin
            state_in = wxh_pkg::MX_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: rtl/word_xor_fmix64_hash.sv
// Word xor fmix64 hash: after acceptance a word runs two multiply passes of MUL0..MUL3
// (six 32x32 products on the shared multiplier) and commits from DONE; a new request is
// taken only once the mixer is back in IDLE. One word in flight.
// A last word's hash is loaded into the output register at commit and may wait there
// while the next words are hashed.
// Synchronous reset: seed and accumulator return to 0x5555AAAA5555AAAA.
`default_nettype none
module word_xor_fmix64_hash (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [wxh_pkg::WordWidth-1:0]   req_word,
   input  wire logic [wxh_pkg::CountWidth-1:0]  req_byte_count,
   input  wire logic                            req_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [wxh_pkg::WordWidth-1:0]   rsp_hash,
   input  wire logic                            csr_wr_en,
   input  wire logic [wxh_pkg::WordWidth-1:0]   csr_wr_data
);

   wxh_pkg::mix_ctrl_type         mix_ctrl;
   wxh_pkg::mix_status_type       mix_status;
   logic [wxh_pkg::WordWidth-1:0] mix_out;
   logic [wxh_pkg::WordWidth-1:0] seed_ff, seed_in;
   logic [wxh_pkg::WordWidth-1:0] acc_ff, acc_in;
   logic [wxh_pkg::WordWidth-1:0] hash_ff, hash_in;
   logic [wxh_pkg::WordWidth-1:0] acc_next;
   logic                          last_ff, last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          accept;

   assign req_ready      = !mix_status.busy;
   assign accept         = req_valid && req_ready;
   assign mix_ctrl.start = accept;
   // a last word commits only once the output register is free
   assign mix_ctrl.ack   = mix_status.done && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign acc_next       = acc_ff ^ mix_out;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash       = hash_ff;

   wxh_mixer u_mixer (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mix_ctrl),
      .din    (wxh_pkg::mask_bytes(req_word, req_byte_count)),
      .status (mix_status),
      .dout   (mix_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= wxh_pkg::SEED_RESET;
         acc_ff       <= wxh_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      last_ff <= last_in;
   end

   always_comb begin
      seed_in      = seed_ff;
      acc_in       = acc_ff;
      hash_in      = hash_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         last_in = req_last;
      end
      if (mix_ctrl.ack) begin
         if (last_ff) begin
            hash_in      = acc_next;
            rsp_valid_in = 1'b1;
            acc_in       = seed_ff;
         end else begin
            acc_in = acc_next;
         end
      end
      // seed write drops the accumulated string; a word still in the mixer folds in later
      if (csr_wr_en) begin
         seed_in = csr_wr_data;
         acc_in  = csr_wr_data;
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for word_xor_fmix64_hash: directed table, then randomized strings.
`timescale 1ns / 1ps
module testbench;

   localparam int Settle   = 16;   // margin for a word still inside the block
   localparam int LongHold = 400;
   localparam int PhaseLen = 142;
   localparam int MaxShown = 10;

   typedef enum logic {
      ROW_WORD,
      ROW_SEED
   } row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [63:0]       word;   // seed value on ROW_SEED rows
      logic [3:0]        count;
      logic              last;
      logic              typed;  // hash below is known up front
      logic [63:0]       hash;
   } plan_row_type;

   localparam logic [63:0] Ones = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_hash;
   logic        csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;

   logic [63:0] seed_model = wxh_pkg::SEED_RESET;
   logic [63:0] acc_model  = wxh_pkg::SEED_RESET;
   logic [63:0] hash_expected[$];
   int          err_count   = 0;
   int          hashes_seen = 0;
   bit          steady      = 1'b0;

   plan_row_type plan [24] = '{
      '{ROW_WORD, Ones,                  4'd0,  1'b1, 1'b1, wxh_pkg::SEED_RESET},
      '{ROW_WORD, 64'h0,                 4'd8,  1'b1, 1'b1, wxh_pkg::SEED_RESET},
      '{ROW_WORD, Ones,                  4'd8,  1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0123456789abcdef,  4'd1,  1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0123456789abcdef,  4'd7,  1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0123456789abcdef,  4'd9,  1'b1, 1'b0, 64'h0},
      '{ROW_WORD, Ones,                  4'd15, 1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h8000000000000001,  4'd8,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h7fffffffffffffff,  4'd8,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'hdeadbeefcafef00d,  4'd3,  1'b1, 1'b0, 64'h0},
      '{ROW_WORD, 64'h1122334455667788,  4'd2,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0,                 4'd0,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'ha5a5a5a5a5a5a5a5,  4'd8,  1'b1, 1'b0, 64'h0},
      '{ROW_SEED, 64'h0,                 4'd0,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, Ones,                  4'd0,  1'b1, 1'b1, 64'h0},
      '{ROW_SEED, Ones,                  4'd0,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h0,                 4'd0,  1'b1, 1'b1, Ones},
      '{ROW_WORD, 64'h0,                 4'd8,  1'b1, 1'b1, Ones},
      '{ROW_WORD, 64'h0f0f0f0f0f0f0f0f,  4'd8,  1'b0, 1'b0, 64'h0},
      // seed write drops the string in progress
      '{ROW_SEED, 64'h0123456789abcdef,  4'd0,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, 64'h5555555555555555,  4'd0,  1'b1, 1'b1, 64'h0123456789abcdef},
      '{ROW_WORD, 64'hfedcba9876543210,  4'd5,  1'b1, 1'b0, 64'h0},
      '{ROW_SEED, wxh_pkg::SEED_RESET,   4'd0,  1'b0, 1'b0, 64'h0},
      '{ROW_WORD, Ones,                  4'd4,  1'b1, 1'b0, 64'h0}
   };

   word_xor_fmix64_hash u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash       (rsp_hash),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [3:0] c);
      if (c >= 4'd8) begin
         return w;
      end
      return w & ((64'd1 << {c, 3'b000}) - 64'd1);
   endfunction

   function automatic logic [63:0] mix_word(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v >> wxh_pkg::MixShift);
      x = x * wxh_pkg::MIX_MUL_A;
      x = x ^ (x >> wxh_pkg::MixShift);
      x = x * wxh_pkg::MIX_MUL_B;
      x = x ^ (x >> wxh_pkg::MixShift);
      return x;
   endfunction

   // mostly short gaps, a few long ones, none in steady phases
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(6, 30);
   endfunction

   task automatic note_error(input string what, input logic [63:0] want, input logic [63:0] got);
      err_count++;
      if (err_count <= MaxShown) begin
         $display("ERROR @%0t: %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   // Hold one request until accepted, then fold it into the running hash.
   task automatic send_word(input logic [63:0] w, input logic [3:0] c, input logic l,
                            input logic typed, input logic [63:0] typed_hash);
      req_valid      <= 1'b1;
      req_word       <= w;
      req_byte_count <= c;
      req_last       <= l;
      do @(posedge clock); while (!req_ready);
      acc_model = acc_model ^ mix_word(keep_bytes(w, c));
      if (l) begin
         hash_expected = {hash_expected, (typed ? typed_hash : acc_model)};
         acc_model = seed_model;
      end
   endtask

   task automatic sender_gap();
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (hash_expected.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] v);
      wait_drained();
      // a non-last request may still be in the mixer
      repeat (Settle) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      seed_model = v;
      acc_model  = v;
   endtask

   // response side: checks hashes and drives rsp_ready
   initial begin
      int          stall_left;
      bit          hold_done;
      logic [63:0] want;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (hash_expected.size() == 0) begin
               note_error("hash with nothing pending", 64'h0, rsp_hash);
            end else begin
               want = hash_expected.pop_front();
               if (rsp_hash !== want) begin
                  note_error("hash", want, rsp_hash);
               end
            end
            hashes_seen++;
         end
         // one long back-pressure window so the block stalls its input
         if (!hold_done && hashes_seen >= 30) begin
            stall_left = LongHold;
            hold_done  = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      int          sent;
      int          len;
      int          r;
      bit          paused;
      logic [3:0]  cnt;
      logic        is_last;
      logic [63:0] next_seed;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_SEED) begin
            write_seed(plan[i].word);
         end else begin
            send_word(plan[i].word, plan[i].count, plan[i].last, plan[i].typed, plan[i].hash);
            sender_gap();
         end
      end

      for (int p = 0; p < 6; p++) begin
         case (p)
            1: begin
               next_seed = '0;
            end
            2: begin
               next_seed = Ones;
            end
            4: begin
               next_seed = wxh_pkg::SEED_RESET;
            end
            default: begin
               next_seed = {$urandom, $urandom};
            end
         endcase
         write_seed(next_seed);
         steady = (p == 2);
         sent   = 0;
         paused = 1'b0;
         while (sent < PhaseLen) begin
            if (p == 3 && sent >= PhaseLen / 2 && !paused) begin
               wait_drained();
               paused = 1'b1;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
            for (int k = 0; k < len; k++) begin
               is_last = (k == len - 1);
               r = $urandom_range(0, 99);
               if (is_last) begin
                  cnt = (r < 70) ? 4'($urandom_range(1, 8)) :
                        (r < 85) ? 4'd0 : 4'($urandom_range(9, 15));
               end else begin
                  // mostly full words mid-string, some odd counts as noise
                  cnt = (r < 85) ? 4'd8 : 4'($urandom_range(0, 15));
               end
               send_word({$urandom, $urandom}, cnt, is_last, 1'b0, 64'h0);
               sender_gap();
               sent++;
            end
         end
      end

      wait_drained();
      repeat (Settle) @(posedge clock);
      if (err_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/wxh_pkg.sv
rtl/wxh_mul_unit.sv
rtl/wxh_mixer.sv
rtl/word_xor_fmix64_hash.sv
tb/sv/testbench.sv
